### src/mie_pkg.sv
package mie_pkg;

    // Major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    localparam logic [4:0]  REG_V0    = 5'd2;
    localparam logic [4:0]  REG_RA    = 5'd31;
    localparam logic [31:0] EXIT_CODE = 32'hA;

    // Execution class chosen by the front end
    typedef enum logic [1:0] {
        CLS_ALU = 2'd0,
        CLS_MEM = 2'd1,
        CLS_MUL = 2'd2,
        CLS_DIV = 2'd3
    } cls_t;

    // One queued word: raw instruction plus decoded read ports and class
    typedef struct packed {
        logic [31:0] instr;
        logic [4:0]  ra;
        logic [4:0]  rb;
        cls_t        cls;
    } qitem_t;

    // Configuration write towards the back end
    typedef struct packed {
        logic        we;
        logic [31:0] value;
    } cfg_t;

endpackage

### src/mips32_instruction_execute_top.sv
// MIPS-I instruction executor.
// Input channel: instruction / in_valid / in_ready carries one instruction
// word, fetched by the user from the next_pc of the previous result (or
// start_pc after reset or a start_pc write).
// Output channel: next_pc, halted, wrote_register, written_index and
// written_value under out_valid / out_ready, one result per word.
// APB port: register 0 (address 0) is start_pc; a write also loads the PC.
// Path from acceptance to result valid: ALU, jump, branch and divide-by-zero
// words go through read and write-back; loads and stores add a memory step,
// multiplies a multiply step, and divides wait for the one-bit-per-cycle
// divider; once halted, a word is answered from idle. The back end runs one
// word at a time; a two-word queue in front takes words while the back end works.
// Reset: register file, HI, LO and PC clear; then a sweep zeroes the data
// memory, during which in_ready stays low.
// A stalled out_ready holds the result and stops the back end from
// starting the next word; the queue fills and then drops in_ready.
module mips32_instruction_execute_top
    import mie_pkg::*;
#(
    parameter int DMEM_WORDS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [31:0] instruction,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [31:0] next_pc,
    output logic        halted,
    output logic        wrote_register,
    output logic [4:0]  written_index,
    output logic [31:0] written_value,
    output logic        out_valid,
    input  logic        out_ready
);

    logic [31:0] start_pc_reg;
    cfg_t        cfg;
    logic        q_valid, q_pop, clearing;
    qitem_t      q_head;

    assign pready = 1'b1;
    assign cfg    = '{we: psel && penable && pwrite && (paddr == 2'd0), value: pwdata};
    assign prdata = start_pc_reg;

    // Hold the start address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_pc_reg <= '0;
        else if (cfg.we)
            start_pc_reg <= pwdata;
    end

    mie_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .instruction (instruction),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .hold        (clearing),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    mie_back #(.DMEM_WORDS(DMEM_WORDS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .next_pc        (next_pc),
        .halted         (halted),
        .wrote_register (wrote_register),
        .written_index  (written_index),
        .written_value  (written_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

### src/mie_front.sv
module mie_front
    import mie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] instruction,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        hold,
    output logic        q_valid,
    output qitem_t      q_head,
    input  logic        q_pop
);

    qitem_t     q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    qitem_t     dec;
    logic       push;
    logic [5:0] op, fn;

    // Classify the incoming word
    always_comb
    begin
        op = instruction[31:26];
        fn = instruction[5:0];
        dec.instr = instruction;
        dec.ra    = instruction[25:21];
        dec.rb    = instruction[20:16];
        dec.cls   = CLS_ALU;
        if (op == OP_SPECIAL) begin
            if (fn == FN_MULT || fn == FN_MULTU)
                dec.cls = CLS_MUL;
            else if (fn == FN_DIV || fn == FN_DIVU)
                dec.cls = CLS_DIV;
            else if (fn == FN_SYSCALL)
                dec.ra = REG_V0;
        end else if (op == OP_LB || op == OP_LH || op == OP_LW || op == OP_LBU
                     || op == OP_LHU || op == OP_SB || op == OP_SH || op == OP_SW) begin
            dec.cls = CLS_MEM;
        end
    end

    assign in_ready = (cnt_reg != 2'd2) && !hold;
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = q_mem_reg[rd_ptr_reg];

    // Store words
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= dec;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, q_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### src/mie_divider.sv
module mie_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted   = {rem_reg, quo_reg[31]};
    assign diff      = {1'b0, shifted} - {2'b00, dvs_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // One restoring step per cycle
    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### src/mie_back.sv
module mie_back
    import mie_pkg::*;
#(
    parameter int DMEM_WORDS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  qitem_t      q_head,
    output logic        q_pop,
    output logic        clearing,
    output logic [31:0] next_pc,
    output logic        halted,
    output logic        wrote_register,
    output logic [4:0]  written_index,
    output logic [31:0] written_value,
    output logic        out_valid,
    input  logic        out_ready
);

    // DMEM_WORDS must be a power of two, which the block does not check: the word index is a mask of the address
    localparam int WIDX = $clog2(DMEM_WORDS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MEM  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_WB   = 6'b100000
    } state_t;

    state_t      state_reg;
    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] dmem [DMEM_WORDS];
    logic [WIDX-1:0] clr_cnt_reg;
    logic        clearing_reg;

    logic [31:0] instr_reg, rda_reg, rdb_reg, pc_reg, hi_reg, lo_reg;
    cls_t        cls_reg;
    logic        running_reg;
    logic [31:0] addr_reg, mv_reg;
    logic [WIDX-1:0] wi_reg;
    logic signed [65:0] prod_reg;
    logic        neg_q_reg, neg_r_reg;
    logic [31:0] npc_reg, wval_reg;
    logic        wr_reg;
    logic [4:0]  widx_reg;

    logic        out_valid_reg, halted_reg, wrote_reg;
    logic [31:0] next_pc_reg, written_value_reg;
    logic [4:0]  written_index_reg;

    logic        out_free, start_item;
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sa;
    logic [31:0] imm, simm, link, btarget, addr_c;
    logic [31:0] npc_c, wval_c, ua, ub;
    logic        wr_c, run_c, hi_we_c, lo_we_c, take_c;
    logic [4:0]  widx_c;
    logic [31:0] hi_c, lo_c;
    logic        div_start;
    logic        div_q_done;
    logic [31:0] div_q, div_r;
    logic        dm_we;
    logic [31:0] dm_wdata, ld_c;
    logic [4:0]  sh8;
    logic        rf_we;

    assign out_free   = !out_valid_reg || out_ready;
    assign start_item = (state_reg == ST_IDLE) && q_valid && !clearing_reg && out_free;
    assign q_pop      = start_item;
    assign clearing   = clearing_reg;

    // Field extraction
    always_comb
    begin
        op      = instr_reg[31:26];
        fn      = instr_reg[5:0];
        rt      = instr_reg[20:16];
        rd      = instr_reg[15:11];
        sa      = instr_reg[10:6];
        imm     = {16'h0, instr_reg[15:0]};
        simm    = {{16{instr_reg[15]}}, instr_reg[15:0]};
        link    = pc_reg + 32'd4;
        btarget = link + {simm[29:0], 2'b00};
        addr_c  = rda_reg + simm;
        ua      = rda_reg[31] ? (32'd0 - rda_reg) : rda_reg;
        ub      = rdb_reg[31] ? (32'd0 - rdb_reg) : rdb_reg;
    end

    // Execute ALU, branch and move operations
    always_comb
    begin
        npc_c   = link;
        wr_c    = 1'b0;
        widx_c  = rt;
        wval_c  = '0;
        run_c   = running_reg;
        hi_we_c = 1'b0;
        lo_we_c = 1'b0;
        hi_c    = rda_reg;
        lo_c    = rda_reg;
        take_c  = 1'b0;
        case (op)
            OP_SPECIAL:
            begin
                widx_c = rd;
                case (fn)
                    FN_SLL:  begin wr_c = 1'b1; wval_c = rdb_reg << sa; end
                    FN_SRL:  begin wr_c = 1'b1; wval_c = rdb_reg >> sa; end
                    FN_SRA:  begin wr_c = 1'b1; wval_c = 32'($signed(rdb_reg) >>> sa); end
                    FN_SLLV: begin wr_c = 1'b1; wval_c = rdb_reg << rda_reg[4:0]; end
                    FN_SRLV: begin wr_c = 1'b1; wval_c = rdb_reg >> rda_reg[4:0]; end
                    FN_SRAV:
                    begin
                        wr_c   = 1'b1;
                        wval_c = 32'($signed(rdb_reg) >>> rda_reg[4:0]);
                    end
                    FN_JR:   npc_c = rda_reg;
                    FN_JALR: begin npc_c = rda_reg; wr_c = 1'b1; wval_c = link; end
                    FN_SYSCALL: if (rda_reg == EXIT_CODE) run_c = 1'b0;
                    FN_MFHI: begin wr_c = 1'b1; wval_c = hi_reg; end
                    FN_MTHI: hi_we_c = 1'b1;
                    FN_MFLO: begin wr_c = 1'b1; wval_c = lo_reg; end
                    FN_MTLO: lo_we_c = 1'b1;
                    FN_DIV, FN_DIVU:
                    begin
                        hi_c = '0;
                        lo_c = '0;
                        hi_we_c = (rdb_reg == 32'd0);
                        lo_we_c = (rdb_reg == 32'd0);
                    end
                    FN_ADD, FN_ADDU: begin wr_c = 1'b1; wval_c = rda_reg + rdb_reg; end
                    FN_SUB, FN_SUBU: begin wr_c = 1'b1; wval_c = rda_reg - rdb_reg; end
                    FN_AND:  begin wr_c = 1'b1; wval_c = rda_reg & rdb_reg; end
                    FN_OR:   begin wr_c = 1'b1; wval_c = rda_reg | rdb_reg; end
                    FN_XOR:  begin wr_c = 1'b1; wval_c = rda_reg ^ rdb_reg; end
                    FN_NOR:  begin wr_c = 1'b1; wval_c = ~(rda_reg | rdb_reg); end
                    FN_SLT:
                    begin
                        wr_c   = 1'b1;
                        wval_c = {31'h0, $signed(rda_reg) < $signed(rdb_reg)};
                    end
                    FN_SLTU: begin wr_c = 1'b1; wval_c = {31'h0, rda_reg < rdb_reg}; end
                    default: ;
                endcase
            end
            OP_REGIMM:
            begin
                if (rt[3:1] == 3'b000) begin
                    take_c = rt[0] ? !rda_reg[31] : rda_reg[31];
                    if (rt[4]) begin
                        wr_c   = 1'b1;
                        widx_c = REG_RA;
                        wval_c = link;
                    end
                end
            end
            OP_J:   npc_c = {pc_reg[31:28], instr_reg[25:0], 2'b00};
            OP_JAL:
            begin
                npc_c  = {pc_reg[31:28], instr_reg[25:0], 2'b00};
                wr_c   = 1'b1;
                widx_c = REG_RA;
                wval_c = link;
            end
            OP_BEQ:  take_c = (rda_reg == rdb_reg);
            OP_BNE:  take_c = (rda_reg != rdb_reg);
            OP_BLEZ: take_c = (rda_reg == 32'd0) || rda_reg[31];
            OP_BGTZ: take_c = (rda_reg != 32'd0) && !rda_reg[31];
            OP_ADDI, OP_ADDIU: begin wr_c = 1'b1; wval_c = rda_reg + simm; end
            OP_SLTI:
            begin
                wr_c   = 1'b1;
                wval_c = {31'h0, $signed(rda_reg) < $signed(simm)};
            end
            OP_SLTIU: begin wr_c = 1'b1; wval_c = {31'h0, rda_reg < simm}; end
            OP_ANDI:  begin wr_c = 1'b1; wval_c = rda_reg & imm; end
            OP_ORI:   begin wr_c = 1'b1; wval_c = rda_reg | imm; end
            OP_XORI:  begin wr_c = 1'b1; wval_c = rda_reg ^ imm; end
            OP_LUI:   begin wr_c = 1'b1; wval_c = {instr_reg[15:0], 16'h0}; end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: wr_c = 1'b1;
            default: ;
        endcase
        if (take_c)
            npc_c = btarget;
    end

    // Load extraction and store merge
    always_comb
    begin
        sh8      = {addr_reg[1:0], 3'b000};
        ld_c     = mv_reg;
        dm_we    = 1'b0;
        dm_wdata = rdb_reg;
        case (op)
            OP_LB:  ld_c = {{24{mv_reg[sh8+7]}}, 8'(mv_reg >> sh8)};
            OP_LBU: ld_c = {24'h0, 8'(mv_reg >> sh8)};
            OP_LH:
                ld_c = addr_reg[1] ? {{16{mv_reg[31]}}, mv_reg[31:16]}
                                   : {{16{mv_reg[15]}}, mv_reg[15:0]};
            OP_LHU: ld_c = addr_reg[1] ? {16'h0, mv_reg[31:16]} : {16'h0, mv_reg[15:0]};
            OP_SB:
            begin
                dm_we    = 1'b1;
                dm_wdata = (mv_reg & ~(32'hFF << sh8)) | ({24'h0, rdb_reg[7:0]} << sh8);
            end
            OP_SH:
            begin
                dm_we    = 1'b1;
                dm_wdata = addr_reg[1] ? {rdb_reg[15:0], mv_reg[15:0]}
                                       : {mv_reg[31:16], rdb_reg[15:0]};
            end
            OP_SW:   dm_we = 1'b1;
            default: ;
        endcase
    end

    assign div_start = (state_reg == ST_READ) && (cls_reg == CLS_DIV) && (rdb_reg != 32'd0);
    assign rf_we     = (state_reg == ST_WB) && wr_reg && (widx_reg != 5'd0);

    mie_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  ((fn == FN_DIV) ? ua : rda_reg),
        .divisor   ((fn == FN_DIV) ? ub : rdb_reg),
        .done      (div_q_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Register file: registered reads, write at write-back
    always_ff @(posedge clk)
    begin
        if (start_item) begin
            rda_reg <= rf_valid_reg[q_head.ra] ? rf_mem[q_head.ra] : '0;
            rdb_reg <= rf_valid_reg[q_head.rb] ? rf_mem[q_head.rb] : '0;
        end
        if (rf_we)
            rf_mem[widx_reg] <= wval_reg;
    end

    // Data memory: clearing sweep, store write, registered read
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            dmem[clr_cnt_reg] <= '0;
        else if (state_reg == ST_MEM && dm_we)
            dmem[wi_reg] <= dm_wdata;
        if (state_reg == ST_READ)
            mv_reg <= dmem[addr_c[WIDX+1:2]];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start_item) begin
            instr_reg <= q_head.instr;
            cls_reg   <= q_head.cls;
        end
        if (state_reg == ST_READ) begin
            addr_reg  <= addr_c;
            wi_reg    <= addr_c[WIDX+1:2];
            npc_reg   <= npc_c;
            wr_reg    <= wr_c;
            widx_reg  <= widx_c;
            wval_reg  <= wval_c;
            neg_q_reg <= (fn == FN_DIV) && (rda_reg[31] != rdb_reg[31]);
            neg_r_reg <= (fn == FN_DIV) && rda_reg[31];
            if (fn == FN_MULT)
                prod_reg <= $signed({rda_reg[31], rda_reg}) * $signed({rdb_reg[31], rdb_reg});
            else
                prod_reg <= $signed({1'b0, rda_reg}) * $signed({1'b0, rdb_reg});
        end
        if (state_reg == ST_MEM)
            wval_reg <= ld_c;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rf_valid_reg  <= '0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            pc_reg        <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            running_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == WIDX'(DMEM_WORDS - 1))
                    clearing_reg <= 1'b0;
            end
            if (cfg.we)
                pc_reg <= cfg.value;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (rf_we)
                rf_valid_reg[widx_reg] <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (start_item) begin
                        if (running_reg) begin
                            state_reg <= ST_READ;
                        end else begin
                            // Halted: report the held PC and drop the word
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_READ:
                begin
                    running_reg <= run_c;
                    if (hi_we_c)
                        hi_reg <= hi_c;
                    if (lo_we_c)
                        lo_reg <= lo_c;
                    case (cls_reg)
                        CLS_MEM: state_reg <= ST_MEM;
                        CLS_MUL: state_reg <= ST_MUL;
                        CLS_DIV: state_reg <= (rdb_reg == 32'd0) ? ST_WB : ST_DIV;
                        default: state_reg <= ST_WB;
                    endcase
                end
                ST_MEM:
                    state_reg <= ST_WB;
                ST_MUL:
                begin
                    hi_reg    <= prod_reg[63:32];
                    lo_reg    <= prod_reg[31:0];
                    state_reg <= ST_WB;
                end
                ST_DIV:
                begin
                    if (div_q_done) begin
                        lo_reg    <= neg_q_reg ? (32'd0 - div_q) : div_q;
                        hi_reg    <= neg_r_reg ? (32'd0 - div_r) : div_r;
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    pc_reg        <= npc_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (start_item && !running_reg) begin
            next_pc_reg       <= pc_reg;
            halted_reg        <= 1'b1;
            wrote_reg         <= 1'b0;
            written_index_reg <= '0;
            written_value_reg <= '0;
        end else if (state_reg == ST_WB) begin
            next_pc_reg       <= npc_reg;
            halted_reg        <= !running_reg;
            wrote_reg         <= rf_we;
            written_index_reg <= rf_we ? widx_reg : 5'd0;
            written_value_reg <= rf_we ? wval_reg : 32'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_pc        = next_pc_reg;
    assign halted         = halted_reg;
    assign wrote_register = wrote_reg;
    assign written_index  = written_index_reg;
    assign written_value  = written_value_reg;

    // Register zero is never written
    assert property (@(posedge clk) disable iff (!rst_n) !rf_valid_reg[0])
        else $error("register zero marked written");

    // No word leaves the queue during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !q_pop)
        else $error("word taken while clearing data memory");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n) div_q_done |-> state_reg == ST_DIV)
        else $error("divider result with nobody waiting");

    // Write-back always finds the result register free
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WB |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

endmodule
